// ===== rtl/assert_macros.svh =====
// ------------------------------------------------------------------------
// assert_macros.svh
// shared assertion shorthands for the weighted selection block
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define CWS_ASSERT_ALWAYS(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CWS_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CWS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cws_pkg.sv =====
// ------------------------------------------------------------------------
// cws_pkg
// shared widths and types of the weighted selection block
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package cws_pkg;

   localparam int SUM_BITS            = 40;
   localparam int WEIGHT_BITS         = 32;
   localparam int FRACTION_BITS       = 32;
   localparam int TAG_BITS            = 32;
   localparam int INDEX_OUT_BITS      = 8;
   // split point of the total for the two partial products
   localparam int MUL_SPLIT           = 32;
   localparam int DEFAULT_TABLE_DEPTH = 256;

   typedef logic [SUM_BITS-1:0] sum_type;

   localparam sum_type SUM_MAX = {SUM_BITS{1'b1}};

endpackage

// ===== rtl/cumulative_weight_select.sv =====
// ------------------------------------------------------------------------
// cumulative_weight_select: weighted selection over running weight sums
// clear, append, no-op: result is held in the pending register, then moved to the output register
// query: scale, the search cell chain, tag and prior-sum fetch, then the pending and output registers
// requests stall from accept until the result moves into the output register
// reset: synchronous, empties the table at once; stored entries are never cleared
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cumulative_weight_select import cws_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_opcode,
   input  logic [WEIGHT_BITS-1:0]    req_weight,
   input  logic [TAG_BITS-1:0]       req_entry_tag,
   input  logic [FRACTION_BITS-1:0]  req_fraction,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [INDEX_OUT_BITS-1:0] rsp_chosen_index,
   output logic [TAG_BITS-1:0]       rsp_chosen_tag,
   output logic [SUM_BITS-1:0]       rsp_offset_in_entry,
   output logic [SUM_BITS-1:0]       rsp_total_weight
);

   localparam int IDX_BITS = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int PHI_BITS = FRACTION_BITS + SUM_BITS - MUL_SPLIT;
   localparam int PLO_BITS = FRACTION_BITS + MUL_SPLIT;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCALE,
      S_SEARCH,
      S_FETCH,
      S_DONE
   } state_type;

   typedef struct packed {
      status_type                status;
      logic [INDEX_OUT_BITS-1:0] index;
      logic [TAG_BITS-1:0]       tag;
      sum_type                   offset;
      sum_type                   total;
   } result_type;

   // control and table bookkeeping
   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   sum_type             total_ff, total_in;
   logic                go_ff, go_in;
   logic                out_valid_ff, out_valid_in;

   // query datapath
   logic [PLO_BITS-1:0] plo_ff, plo_in;
   logic [PHI_BITS-1:0] phi_ff, phi_in;
   sum_type             target_ff, target_in;
   logic [IDX_BITS-1:0] sel_ff, sel_in;
   sum_type             fetch_tgt_ff, fetch_tgt_in;

   // finished result and output register
   result_type          pend_ff, pend_in;
   result_type          out_ff, out_in;

   logic                accept;
   logic                out_free;
   logic                wr_en;
   logic [IDX_BITS-1:0] wr_index;
   logic [SUM_BITS:0]   sum_wide;
   sum_type             sat_sum;
   logic [SUM_BITS:0]   tgt_wide;
   logic [IDX_BITS-1:0] sel_pick;
   logic [IDX_BITS-1:0] before_addr;
   sum_type             before_rd;
   sum_type             before_sum;
   sum_type             offset;
   logic [TAG_BITS-1:0] tag_rd;

   // search chain links, node IDX_BITS is the launch point, node 0 the result
   logic [IDX_BITS:0]   link_valid;
   logic [IDX_BITS-1:0] link_pos    [IDX_BITS+1];
   sum_type             link_target [IDX_BITS+1];

   // one transaction at a time, the output register decouples the response side
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // running sum of a new entry saturates at the top of the sum range
   assign sum_wide = {1'b0, total_ff} + (SUM_BITS + 1)'(req_weight);
   assign sat_sum  = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];

   // appended entry lands at the current fill position
   assign wr_index = count_ff[IDX_BITS-1:0];
   assign wr_en    = accept && (opcode_type'(req_opcode) == OP_APPEND)
                     && (count_ff != CNT_BITS'(TABLE_DEPTH));

   // target = floor(fraction * total / 2^32) from the two partial products
   assign tgt_wide = (SUM_BITS + 1)'(phi_ff)
                     + (SUM_BITS + 1)'(plo_ff[PLO_BITS-1:FRACTION_BITS]);

   // no entry above the target picks the last entry
   assign sel_pick    = (CNT_BITS'(link_pos[0]) >= count_ff)
                        ? IDX_BITS'(count_ff - 1'b1) : link_pos[0];
   assign before_addr = sel_pick - 1'b1;

   // offset against the sum of all entries before the selected one
   assign before_sum = (sel_ff == '0) ? '0 : before_rd;
   assign offset     = (fetch_tgt_ff >= before_sum) ? (fetch_tgt_ff - before_sum) : '0;

   // full copies of sums and tags for the final lookup
   cws_ram #(
      .WIDTH (SUM_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_index),
      .wr_data (sat_sum),
      .rd_addr (before_addr),
      .rd_data (before_rd)
   );

   cws_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_index),
      .wr_data (req_entry_tag),
      .rd_addr (sel_pick),
      .rd_data (tag_rd)
   );

   // chain of search cells, most significant index bit first
   assign link_valid[IDX_BITS]  = go_ff;
   assign link_pos[IDX_BITS]    = '0;
   assign link_target[IDX_BITS] = target_ff;

   for (genvar g = 0; g < IDX_BITS; g++) begin : g_cell
      cws_cell #(
         .IDX_BITS (IDX_BITS),
         .CNT_BITS (CNT_BITS),
         .LEVEL    (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (wr_en),
         .wr_index   (wr_index),
         .wr_sum     (sat_sum),
         .count      (count_ff),
         .in_valid   (link_valid[g+1]),
         .in_pos     (link_pos[g+1]),
         .in_target  (link_target[g+1]),
         .out_valid  (link_valid[g]),
         .out_pos    (link_pos[g]),
         .out_target (link_target[g])
      );
   end

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      go_in        = 1'b0;
      out_valid_in = out_valid_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      target_in    = target_ff;
      sel_in       = sel_ff;
      fetch_tgt_in = fetch_tgt_ff;
      pend_in      = pend_ff;
      out_in       = out_ff;

      // response taken
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            // partial products of fraction and total, used only by a query
            plo_in = PLO_BITS'(req_fraction) * PLO_BITS'(total_ff[MUL_SPLIT-1:0]);
            phi_in = PHI_BITS'(req_fraction) * PHI_BITS'(total_ff[SUM_BITS-1:MUL_SPLIT]);
            if (accept) begin
               pend_in  = '{status: STAT_OK, index: '0, tag: '0, offset: '0,
                            total: total_ff};
               state_in = S_DONE;
               unique case (opcode_type'(req_opcode))
                  OP_CLEAR: begin
                     count_in      = '0;
                     total_in      = '0;
                     pend_in.total = '0;
                  end
                  OP_APPEND: begin
                     if (count_ff == CNT_BITS'(TABLE_DEPTH)) begin
                        pend_in.status = STAT_FULL;
                     end else begin
                        count_in      = count_ff + 1'b1;
                        total_in      = sat_sum;
                        pend_in.total = sat_sum;
                     end
                  end
                  OP_QUERY: begin
                     if (count_ff == '0) begin
                        pend_in.status = STAT_EMPTY;
                     end else begin
                        state_in = S_SCALE;
                     end
                  end
                  default: begin
                     pend_in.status = STAT_OK;
                  end
               endcase
            end
         end
         S_SCALE: begin
            target_in = tgt_wide[SUM_BITS-1:0];
            go_in     = 1'b1;
            state_in  = S_SEARCH;
         end
         S_SEARCH: begin
            // chain result issues the tag and prior-sum reads
            if (link_valid[0]) begin
               sel_in       = sel_pick;
               fetch_tgt_in = link_target[0];
               state_in     = S_FETCH;
            end
         end
         S_FETCH: begin
            pend_in  = '{status: STAT_OK, index: INDEX_OUT_BITS'(sel_ff), tag: tag_rd,
                         offset: offset, total: total_ff};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               out_in       = pend_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         go_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         go_ff        <= go_in;
         out_valid_ff <= out_valid_in;
      end
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      target_ff    <= target_in;
      sel_ff       <= sel_in;
      fetch_tgt_ff <= fetch_tgt_in;
      pend_ff      <= pend_in;
      out_ff       <= out_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_ff.status;
   assign rsp_chosen_index    = out_ff.index;
   assign rsp_chosen_tag      = out_ff.tag;
   assign rsp_offset_in_entry = out_ff.offset;
   assign rsp_total_weight    = out_ff.total;

   // fill count never passes the table depth
   `CWS_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_BITS'(TABLE_DEPTH), "entry count beyond table depth")
   // a nonzero total needs at least one entry
   `CWS_ASSERT_IMPLY(a_total_count, clock, reset, total_ff != '0, count_ff != '0, "total without entries")
   // the search chain only reports while a query waits for it
   `CWS_ASSERT_IMPLY(a_chain_state, clock, reset, link_valid[0], state_ff == S_SEARCH, "search result outside search")
   // selected entry is always a written one
   `CWS_ASSERT_IMPLY(a_sel_range, clock, reset, state_ff == S_FETCH, CNT_BITS'(sel_ff) < count_ff, "selected entry beyond fill count")
   // an accepted transaction closes the request side
   `CWS_ASSERT_NEXT(a_accept_busy, clock, reset, accept, req_stall, "request open while busy")

endmodule

// ===== rtl/cws_ram.sv =====
// ------------------------------------------------------------------------
// cws_ram
// simple dual-port ram, one write and one registered read per cycle
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module cws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cws_cell.sv =====
// ------------------------------------------------------------------------
// cws_cell
// one search level: holds the running sums probed at this level and
// decides one bit of the selected index
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module cws_cell import cws_pkg::*; #(
   parameter int IDX_BITS = 8,
   parameter int CNT_BITS = 9,
   parameter int LEVEL    = 0
) (
   input  logic                clock,
   input  logic                reset,
   // table append
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] wr_index,
   input  sum_type             wr_sum,
   input  logic [CNT_BITS-1:0] count,
   // search link from the next higher level
   input  logic                in_valid,
   input  logic [IDX_BITS-1:0] in_pos,
   input  sum_type             in_target,
   // search link to the next lower level
   output logic                out_valid,
   output logic [IDX_BITS-1:0] out_pos,
   output sum_type             out_target
);

   // entries whose index ends in exactly LEVEL ones live here
   localparam int LVL_RAW   = 1 << (IDX_BITS - 1 - LEVEL);
   localparam int LVL_DEPTH = (LVL_RAW < 2) ? 2 : LVL_RAW;
   localparam int LVL_ADDR  = $clog2(LVL_DEPTH);

   localparam logic [IDX_BITS-1:0] ONES_MASK = IDX_BITS'((1 << LEVEL) - 1);
   localparam logic [IDX_BITS-1:0] PAIR_MASK = IDX_BITS'((2 << LEVEL) - 1);
   localparam logic [IDX_BITS-1:0] STEP      = IDX_BITS'(1 << LEVEL);

   logic                valid_ff, valid_in;
   logic [IDX_BITS-1:0] pos_ff, pos_in;
   sum_type             target_ff, target_in;
   logic                inrange_ff, inrange_in;

   logic [IDX_BITS-1:0] probe;
   logic                lvl_we;
   sum_type             probe_sum;
   logic                take;

   assign probe  = in_pos | ONES_MASK;
   assign lvl_we = wr_en && ((wr_index & PAIR_MASK) == ONES_MASK);

   cws_ram #(
      .WIDTH (SUM_BITS),
      .DEPTH (LVL_DEPTH)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (LVL_ADDR'(wr_index >> (LEVEL + 1))),
      .wr_data (wr_sum),
      .rd_addr (LVL_ADDR'(probe >> (LEVEL + 1))),
      .rd_data (probe_sum)
   );

   always_comb begin
      valid_in   = in_valid;
      pos_in     = in_pos;
      target_in  = in_target;
      inrange_in = CNT_BITS'(probe) < count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      pos_ff     <= pos_in;
      target_ff  <= target_in;
      inrange_ff <= inrange_in;
   end

   // step past the probed entry when its running sum does not exceed the target
   assign take       = inrange_ff && (probe_sum <= target_ff);
   assign out_valid  = valid_ff;
   assign out_pos    = take ? (pos_ff | STEP) : pos_ff;
   assign out_target = target_ff;

endmodule
